>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output spq_pkg::ctrl_cmd_t     cmd
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/spq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module spq_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  spq_pkg::ctrl_cmd_t                       cmd,
  input  spq_pkg::op_t                             op_in,
  input  wire logic signed [spq_pkg::DATA_W-1:0]   data_in,
  input  wire logic [spq_pkg::PRIO_W-1:0]          prio_in,
  output spq_pkg::status_t                         status,
  output logic signed [spq_pkg::DATA_W-1:0]        data_out,
  output logic [spq_pkg::PRIO_W-1:0]               prio_out,
  output logic                                     empty_res
);
  import spq_pkg::*;

  // latched input word
  op_t                     op_r;
  logic signed [DATA_W-1:0] din_r;
  logic [PRIO_W-1:0]        pin_r;

  // sorted store, slot 0 is the front
  logic signed [DATA_W-1:0] val_r [DEPTH];
  logic [PRIO_W-1:0]        pri_r [DEPTH];
  logic signed [DATA_W-1:0] val_nxt [DEPTH];
  logic [PRIO_W-1:0]        pri_nxt [DEPTH];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] dout_r, dout_nxt;
  logic [PRIO_W-1:0]        pout_r, pout_nxt;
  logic                     empty_r, empty_nxt;

  logic [DEPTH-1:0] ge;
  logic             full, empty, wr_en;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < cnt_r) && (pri_r[i] >= pin_r);
    end
  end

  // enqueue: keep entries ahead, drop new one at the first slot that
  // fails the compare, shift the rest back by one; dequeue: shift all forward by one
  always_comb begin
    if (op_r == OP_ENQ) begin
      val_nxt[0] = ge[0] ? val_r[0] : din_r;
      pri_nxt[0] = ge[0] ? pri_r[0] : pin_r;
      for (int i = 1; i < DEPTH; i++) begin
        if (ge[i]) begin
          val_nxt[i] = val_r[i];
          pri_nxt[i] = pri_r[i];
        end else if (ge[i-1]) begin
          val_nxt[i] = din_r;
          pri_nxt[i] = pin_r;
        end else begin
          val_nxt[i] = val_r[i-1];
          pri_nxt[i] = pri_r[i-1];
        end
      end
    end else begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        val_nxt[i] = val_r[i+1];
        pri_nxt[i] = pri_r[i+1];
      end
      val_nxt[DEPTH-1] = val_r[DEPTH-1];
      pri_nxt[DEPTH-1] = pri_r[DEPTH-1];
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    dout_nxt   = '0;
    pout_nxt   = '0;
    empty_nxt  = (op_r == OP_DEQ) && (cnt_r <= CNT_W'(1));
    unique case (op_r)
      OP_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          wr_en    = 1'b1;
          cnt_nxt  = cnt_r - CNT_W'(1);
          dout_nxt = val_r[0];
          pout_nxt = pri_r[0];
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_in;
      din_r <= data_in;
      pin_r <= prio_in;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
      pout_r   <= pout_nxt;
      empty_r  <= empty_nxt;
    end
    if (cmd.exec && wr_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
    end
  end

  assign status    = status_r;
  assign data_out  = dout_r;
  assign prio_out  = pout_r;
  assign empty_res = empty_r;

endmodule
`default_nettype wire

>>> rtl/core/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | data_in[31:0], prio_in[39:32]               | cmd
// out_    | out | data_out[31:0], prio_out[39:32], empty[40]  | status
//
// Each word is first latched, then all slots are compared in parallel
// and the sorted store is shifted; no input word is taken during that shift.
// A result word waits in the output register; the next input word is
// taken meanwhile, and its execution holds until that register frees.
// Synchronous active-low reset empties the queue; slot contents are
// not cleared.
module sorted_priority_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // data_in, prio_in
  input  wire logic [0:0]  in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // data_out, prio_out, empty_res, zero pad
  output logic [1:0]       out_tuser   // status
);
  import spq_pkg::*;

  ctrl_cmd_t                cmd;
  status_t                  status;
  logic signed [DATA_W-1:0] data_out;
  logic [PRIO_W-1:0]        prio_out;
  logic                     empty_res;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .op_in     (op_t'(in_tuser[0])),
    .data_in   (signed'(in_tdata[31:0])),
    .prio_in   (in_tdata[39:32]),
    .status    (status),
    .data_out  (data_out),
    .prio_out  (prio_out),
    .empty_res (empty_res)
  );

  assign out_tdata = {7'd0, empty_res, prio_out, data_out};
  assign out_tuser = status;

endmodule
`default_nettype wire
